// ===== rtl/ssd_pkg.sv =====
// Shared types, glyph codes and helpers for the seven-segment scan driver.
// No dependencies; every other file imports this package.
package ssd_pkg;

    // Blink counter bounds.
    localparam logic [7:0] BLINK_PERIOD = 8'd201;
    localparam logic [7:0] BLINK_HALF   = 8'd100;

    // Display modes.
    localparam logic [3:0] MODE_LOGO      = 4'd0;
    localparam logic [3:0] MODE_FREQ      = 4'd1;
    localparam logic [3:0] MODE_UPPER     = 4'd2;
    localparam logic [3:0] MODE_LOWER     = 4'd3;
    localparam logic [3:0] MODE_ALARM     = 4'd4;
    localparam logic [3:0] MODE_AMPL      = 4'd5;
    localparam logic [3:0] MODE_TRIG_TIME = 4'd6;
    localparam logic [3:0] MODE_SCAN_INT  = 4'd7;
    localparam logic [3:0] MODE_SOFT     = 4'd8;
    localparam logic [3:0] MODE_MAX_POWER = 4'd9;
    localparam logic [3:0] MODE_END       = 4'd10;

    // Fixed glyphs and the decimal point bit.
    localparam logic [7:0] SEG_DP        = 8'h20;
    localparam logic [7:0] SEG_BAR       = 8'h08;
    localparam logic [7:0] SEG_LOGO_HI   = 8'hD6;
    localparam logic [7:0] SEG_LOGO_MID  = 8'hED;
    localparam logic [7:0] SEG_LOGO_LO   = 8'h14;
    localparam logic [7:0] SEG_UPPER     = 8'h9E;
    localparam logic [7:0] SEG_LOWER     = 8'hC2;
    localparam logic [7:0] SEG_ALARM     = 8'hCB;
    localparam logic [7:0] SEG_AMPL      = 8'h8F;
    localparam logic [7:0] SEG_SCAN_INT  = 8'h88;
    localparam logic [7:0] SEG_SOFT      = 8'hC3;
    localparam logic [7:0] SEG_BLANK     = 8'h00;

    // Active-low digit selects.
    localparam logic [7:0] SEL_DIGIT0 = 8'hFE;
    localparam logic [7:0] SEL_DIGIT1 = 8'hFD;
    localparam logic [7:0] SEL_DIGIT2 = 8'hFB;
    localparam logic [7:0] SEL_DIGIT3 = 8'hF7;

    // Input beat payload.
    typedef struct packed {
        logic [3:0]  mode;
        logic [16:0] value;
        logic [2:0]  cursor;
    } ssd_in_t;

    // Result beat payload.
    typedef struct packed {
        logic [7:0] segments;
        logic [7:0] digit_select;
    } ssd_out_t;

    // Five decimal digits of the value, index 0 is the units digit.
    typedef logic [4:0][3:0] ssd_digits_t;

    // Segment bytes of the four display positions, index 0 is rightmost.
    typedef logic [3:0][7:0] ssd_glyphs_t;

    // Segment pattern of one decimal digit.
    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] g;
        case (d)
            4'd0: g = 8'hD7;
            4'd1: g = 8'h14;
            4'd2: g = 8'hCD;
            4'd3: g = 8'h5D;
            4'd4: g = 8'h1E;
            4'd5: g = 8'h5B;
            4'd6: g = 8'hDB;
            4'd7: g = 8'h15;
            4'd8: g = 8'hDF;
            4'd9: g = 8'h5F;
            default: g = SEG_BLANK;
        endcase
        return g;
    endfunction

    // Active-low select for a scan position.
    function automatic logic [7:0] digit_select_code(input logic [1:0] pos);
        logic [7:0] s;
        case (pos)
            2'd0: s = SEL_DIGIT0;
            2'd1: s = SEL_DIGIT1;
            2'd2: s = SEL_DIGIT2;
            2'd3: s = SEL_DIGIT3;
            default: s = SEL_DIGIT0;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/ssd_dec_split.sv =====
// Splits a 17-bit value into five decimal digits by reciprocal multiplies.
// Depends on ssd_pkg for the digit vector type.
module ssd_dec_split
    import ssd_pkg::*;
(
    input  logic [16:0]  value,
    output ssd_digits_t  digits
);

    // Quotients by powers of ten; the reciprocals are exact for 17-bit inputs.
    logic [32:0] prod_10;
    logic [34:0] prod_100;
    logic [34:0] prod_1000;
    logic [34:0] prod_10000;
    logic [13:0] q1;
    logic [10:0] q2;
    logic [7:0]  q3;
    logic [3:0]  q4;
    logic        q5;

    assign prod_10    = 33'(value) * 33'd52429;
    assign prod_100   = 35'(value) * 35'd167773;
    assign prod_1000  = 35'(value) * 35'd134218;
    assign prod_10000 = 35'(value) * 35'd214749;

    assign q1 = prod_10[32:19];
    assign q2 = prod_100[34:24];
    assign q3 = prod_1000[34:27];
    assign q4 = prod_10000[34:31];
    assign q5 = (value >= 17'd100000);

    // Each digit is its quotient minus ten times the next quotient.
    logic [16:0] rem0;
    logic [13:0] rem1;
    logic [10:0] rem2;
    logic [7:0]  rem3;
    logic [3:0]  rem4;

    assign rem0 = value - (17'({q1, 3'b000}) + 17'({q1, 1'b0}));
    assign rem1 = q1 - (14'({q2, 3'b000}) + 14'({q2, 1'b0}));
    assign rem2 = q2 - (11'({q3, 3'b000}) + 11'({q3, 1'b0}));
    assign rem3 = q3 - (8'({q4, 3'b000}) + 8'({q4, 1'b0}));
    assign rem4 = q4 - (q5 ? 4'd10 : 4'd0);

    assign digits[0] = rem0[3:0];
    assign digits[1] = rem1[3:0];
    assign digits[2] = rem2[3:0];
    assign digits[3] = rem3[3:0];
    assign digits[4] = rem4;

endmodule

// ===== rtl/ssd_glyph.sv =====
// Builds the four segment bytes of the display from the mode and the digits.
// Depends on ssd_pkg for glyph codes, modes and the digit lookup.
module ssd_glyph
    import ssd_pkg::*;
(
    input  logic [3:0]   mode,
    input  ssd_digits_t  digits,
    output ssd_glyphs_t  glyphs
);

    // Digit patterns, index k is the digit of value divided by ten to the k.
    logic [4:0][7:0] dg;

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            dg[k] = digit_glyph(digits[k]);
        end
    end

    // Per-mode layout; unassigned modes stay blank.
    always_comb begin
        glyphs = '0;
        case (mode)
            MODE_LOGO: begin
                glyphs[3] = SEG_LOGO_HI;
                glyphs[2] = SEG_BAR;
                glyphs[1] = SEG_LOGO_MID;
                glyphs[0] = SEG_LOGO_LO;
            end
            MODE_FREQ, MODE_TRIG_TIME: begin
                glyphs[3] = dg[3];
                glyphs[2] = dg[2] | SEG_DP;
                glyphs[1] = dg[1];
                glyphs[0] = dg[0];
            end
            MODE_UPPER, MODE_LOWER: begin
                glyphs[3] = (mode == MODE_UPPER) ? SEG_UPPER : SEG_LOWER;
                glyphs[2] = dg[4];
                glyphs[1] = dg[3] | SEG_DP;
                glyphs[0] = dg[2];
            end
            MODE_ALARM: begin
                glyphs[3] = SEG_ALARM;
                glyphs[2] = SEG_BAR;
                glyphs[1] = dg[1];
                glyphs[0] = dg[0];
            end
            MODE_AMPL: begin
                glyphs[3] = SEG_AMPL;
                glyphs[2] = dg[3];
                glyphs[1] = dg[2];
                glyphs[0] = dg[1];
            end
            MODE_SCAN_INT, MODE_SOFT: begin
                glyphs[3] = (mode == MODE_SCAN_INT) ? SEG_SCAN_INT : SEG_SOFT;
                glyphs[2] = dg[2];
                glyphs[1] = dg[1];
                glyphs[0] = dg[0];
            end
            MODE_MAX_POWER: begin
                glyphs[3] = SEG_AMPL;
                glyphs[2] = dg[2] | SEG_DP;
                glyphs[1] = dg[1];
                glyphs[0] = dg[0];
            end
            MODE_END: begin
                glyphs[3] = SEG_BAR;
                glyphs[2] = SEG_BAR;
                glyphs[1] = SEG_BAR;
                glyphs[0] = SEG_BAR;
            end
            default: begin
                glyphs = '0;
            end
        endcase
    end

endmodule

// ===== rtl/seven_segment_scan_with_blink.sv =====
// Top level of the seven-segment scan driver with cursor blink.
// A beat waits in the input register; its result goes to the result register.
// Throughput: one beat per cycle unless the sink stalls, set by the input
// register feeding the result register through the decimal split and glyph
// logic. Reset (aresetn low, synchronous) empties both registers and clears the
// scan position and blink counter. Depends on ssd_pkg, ssd_dec_split, ssd_glyph.
module seven_segment_scan_with_blink
    import ssd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ssd_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ssd_out_t m_data
);

    logic        in_valid_reg;
    ssd_in_t     in_data_reg;
    logic        out_valid_reg;
    ssd_out_t    out_data_reg;
    logic [1:0]  scan_pos_reg;
    logic [7:0]  blink_count_reg;

    logic        advance;
    ssd_digits_t digits;
    ssd_glyphs_t glyphs;
    logic [7:0]  blink_base;
    logic [7:0]  blink_count_next;
    logic        blank;
    ssd_out_t    out_data_next;

    // The held beat moves on whenever the result register is free or drains.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Digit extraction and per-mode glyph layout.
    ssd_dec_split u_dec_split (
        .value  (in_data_reg.value),
        .digits (digits)
    );

    ssd_glyph u_glyph (
        .mode   (in_data_reg.mode),
        .digits (digits),
        .glyphs (glyphs)
    );

    // Blink counter step; a zero cursor restarts the count first.
    always_comb begin
        blink_base = (in_data_reg.cursor == 3'd0) ? 8'd0 : blink_count_reg;
        if (blink_base >= BLINK_PERIOD) begin
            blink_count_next = 8'd0;
        end else begin
            blink_count_next = blink_base + 8'd1;
        end
        blank = (in_data_reg.cursor == ({1'b0, scan_pos_reg} + 3'd1))
                && (blink_count_next > BLINK_HALF);
    end

    // Scanned digit and its select.
    always_comb begin
        out_data_next.segments     = blank ? SEG_BLANK : glyphs[scan_pos_reg];
        out_data_next.digit_select = digit_select_code(scan_pos_reg);
    end

    // Scan state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            scan_pos_reg    <= 2'd0;
            blink_count_reg <= 8'd0;
        end else begin
            if (advance) begin
                out_valid_reg   <= 1'b1;
                scan_pos_reg    <= scan_pos_reg + 2'd1;
                blink_count_reg <= blink_count_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // The counter never passes its period.
    a_blink_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        blink_count_reg <= BLINK_PERIOD)
        else $error("blink counter above period");

    // Exactly one digit is selected on every result beat.
    a_select_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot(~m_data.digit_select))
        else $error("digit select not one-hot");

    // Each forwarded beat steps the scan position by one.
    a_scan_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> scan_pos_reg == $past(scan_pos_reg) + 2'd1)
        else $error("scan position did not advance");

    // A held beat that cannot move on is not dropped.
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input beat lost");

    // A result stalled by the sink keeps its content.
    a_hold_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled result changed");

endmodule
